// File: rtl/core/mbw_pkg.sv
package mbw_pkg;

	localparam int MAZE_SIDE   = 16;
	localparam int COORD_W     = 4;
	localparam int STACK_DEPTH = 256;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int QDEPTH      = 2;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int QCW         = $clog2(QDEPTH + 1);

	// directions
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	// stack fault codes
	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_POP  = 2'd1;
	localparam logic [1:0] FAULT_PUSH = 2'd2;

	// config register indexes
	localparam logic [1:0] REG_EXIT_X  = 2'd0;
	localparam logic [1:0] REG_EXIT_Y  = 2'd1;
	localparam logic [1:0] REG_ENTRY_X = 2'd2;
	localparam logic [1:0] REG_ENTRY_Y = 2'd3;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} mbw_pos_t;

	typedef struct packed {
		logic [3:0] untried;
		logic [1:0] come;
	} mbw_frame_t;

	// classified step, as queued between front and back
	typedef struct packed {
		coord_t     cell_x;
		coord_t     cell_y;
		logic [3:0] open_dirs;
		logic       at_entry;
	} mbw_item_t;

	typedef struct packed {
		logic      valid;
		mbw_item_t item;
	} mbw_qlink_t;

	typedef struct packed {
		logic             load;
		logic [1:0]       fault;
		logic [CNT_W-1:0] count;
	} mbw_stat_t;

	function automatic logic [1:0] reverse_dir(input logic [1:0] d);
		return d ^ 2'b01;
	endfunction

	function automatic logic [3:0] dir_flag(input logic [1:0] d);
		return 4'b0001 << d;
	endfunction

endpackage

// File: rtl/core/mbw_step_if.sv
interface mbw_step_if import mbw_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t cell_x;
	coord_t cell_y;
	logic [3:0] wall_bits;

	modport source(output valid, output cell_x, output cell_y, output wall_bits, input ready);
	modport sink(input valid, input cell_x, input cell_y, input wall_bits, output ready);
endinterface

// File: rtl/core/mbw_move_if.sv
interface mbw_move_if import mbw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] move_dir;
	logic       is_retreat;
	logic [1:0] stack_fault;

	modport source(output valid, output move_dir, output is_retreat, output stack_fault,
		input ready);
	modport sink(input valid, input move_dir, input is_retreat, input stack_fault,
		output ready);
endinterface

// File: rtl/core/maze_backtrack_walker.sv
// Depth-first maze walker with a backtracking frame stack.
// Channels: step (sink) takes one walker step: cell_x, cell_y and the four
// wall bits (left, right, up, down; 1 = wall). result (source) returns one
// item per step: move_dir, is_retreat and stack_fault. Both use valid/ready.
// Configuration: cfg_wr_en/cfg_index/cfg_data write exit_x, exit_y, entry_x,
// entry_y (indexes 0..3); write only while no step is in flight.
// Steps enter a two-entry queue, so step.ready stays high while the back end
// works. The back end handles a forward push in states IDLE and DEC, and a
// retreat pop in IDLE, FIX and DEC (FIX only when a frame lies below the
// cached top: the pop reads that frame from the stack memory, then writes it
// back with the untried flag of the retreated direction cleared).
// A result waits in the output register while result.ready is low; the back
// end prepares the next step meanwhile, and the queue fills, then step.ready
// drops. Reset empties the queue and the stack, sets the walker to advancing
// with last direction left and clears the config registers. The stack
// memory needs no clearing: only frames below the count are ever read.
module maze_backtrack_walker import mbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mbw_step_if.sink    step,
	mbw_move_if.source  result,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  coord_t      cfg_data
);

	mbw_pos_t   exit_q;
	mbw_pos_t   entry_q;
	mbw_qlink_t qlink;
	logic       q_ready;
	mbw_stat_t  stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_q  <= '0;
			entry_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EXIT_X:  exit_q.x  <= cfg_data;
				REG_EXIT_Y:  exit_q.y  <= cfg_data;
				REG_ENTRY_X: entry_q.x <= cfg_data;
				REG_ENTRY_Y: entry_q.y <= cfg_data;
				default:     exit_q    <= exit_q;
			endcase
		end
	end

	mbw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.entry   (entry_q),
		.q_out   (qlink),
		.q_ready (q_ready)
	);

	mbw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_in     (qlink),
		.q_ready  (q_ready),
		.exit_pos (exit_q),
		.result   (result),
		.stat     (stat)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(STACK_DEPTH))
		else $error("frame count beyond stack depth");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |=> result.valid)
		else $error("result not presented after load");

	a_push_fault: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load && stat.fault == FAULT_PUSH |-> stat.count == CNT_W'(STACK_DEPTH))
		else $error("push fault with room on stack");

	a_pop_fault: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load && stat.fault == FAULT_POP |-> stat.count == '0)
		else $error("pop fault with frames on stack");

endmodule

// File: rtl/core/mbw_front.sv
module mbw_front import mbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mbw_step_if.sink    step,
	input  mbw_pos_t    entry,
	output mbw_qlink_t  q_out,
	input  logic        q_ready
);

	mbw_item_t        slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             push;
	logic             pop;
	mbw_item_t        cls;

	// classify: open directions and entrance match
	always_comb begin
		cls.cell_x    = step.cell_x;
		cls.cell_y    = step.cell_y;
		cls.open_dirs = ~step.wall_bits;
		cls.at_entry  = (step.cell_x == entry.x) && (step.cell_y == entry.y);
	end

	assign step.ready  = (cnt_q != QCW'(QDEPTH));
	assign push        = step.valid && step.ready;
	assign q_out.valid = (cnt_q != '0);
	assign q_out.item  = slot_q[rd_ptr_q];
	assign pop         = q_out.valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/mbw_back.sv
module mbw_back import mbw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mbw_qlink_t  q_in,
	output logic        q_ready,
	input  mbw_pos_t    exit_pos,
	mbw_move_if.source  result,
	output mbw_stat_t   stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIX  = 2'd1;
	localparam logic [1:0] ST_DEC  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             adv_q;
	logic [1:0]       last_q;
	mbw_frame_t       top_q;
	coord_t           cx_q;
	coord_t           cy_q;
	logic [1:0]       fault_q;
	logic [1:0]       pop_dir_q;

	mbw_frame_t       mem [STACK_DEPTH];
	mbw_frame_t       rd_q;
	logic             mem_we;
	logic [STK_AW-1:0] mem_wa;
	logic [STK_AW-1:0] mem_ra;
	mbw_frame_t       mem_wd;

	logic             out_valid_q;
	logic [1:0]       out_dir_q;
	logic             out_ret_q;
	logic [1:0]       out_fault_q;

	// front-of-step values after the entrance reset
	logic             take;
	logic [CNT_W-1:0] cnt_e;
	logic             adv_e;
	logic [1:0]       last_e;
	mbw_frame_t       new_frame;
	logic [CNT_W-1:0] cnt_m2;
	mbw_frame_t       fixed;

	// decision
	mbw_frame_t       cur;
	logic [2:0]       n_open;
	logic [1:0]       fallback;
	logic [1:0]       dec_dir;
	logic             dec_ret;
	logic             load;

	assign q_ready = (state_q == ST_IDLE);
	assign take    = q_in.valid && q_ready;

	always_comb begin
		cnt_e  = q_in.item.at_entry ? '0 : count_q;
		adv_e  = q_in.item.at_entry | adv_q;
		last_e = q_in.item.at_entry ? DIR_LEFT : last_q;
		new_frame.come    = last_e;
		new_frame.untried = q_in.item.open_dirs & ~dir_flag(reverse_dir(last_e));
		cnt_m2 = cnt_e - CNT_W'(2);
		fixed.come    = rd_q.come;
		fixed.untried = rd_q.untried & ~dir_flag(pop_dir_q);
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_e[STK_AW-1:0];
		mem_wd = new_frame;
		mem_ra = cnt_m2[STK_AW-1:0];
		if (state_q == ST_IDLE) begin
			mem_we = take && adv_e && (cnt_e != CNT_W'(STACK_DEPTH));
		end else if (state_q == ST_FIX) begin
			mem_we = 1'b1;
			mem_wa = STK_AW'(count_q - 1'b1);
			mem_wd = fixed;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// move choice from the top frame
	always_comb begin
		cur      = (count_q == '0) ? '0 : top_q;
		n_open   = 3'($countones(cur.untried));
		dec_ret  = 1'b0;
		if (cur.untried[DIR_UP])          fallback = DIR_UP;
		else if (cur.untried[DIR_DOWN])   fallback = DIR_DOWN;
		else if (cur.untried[DIR_LEFT])   fallback = DIR_LEFT;
		else if (cur.untried[DIR_RIGHT])  fallback = DIR_RIGHT;
		else                              fallback = DIR_LEFT;

		if (cx_q > exit_pos.x && cur.untried[DIR_LEFT]) begin
			dec_dir = DIR_LEFT;
		end else if (cx_q < exit_pos.x && cur.untried[DIR_RIGHT]) begin
			dec_dir = DIR_RIGHT;
		end else if (cy_q > exit_pos.y && cur.untried[DIR_UP]) begin
			dec_dir = DIR_UP;
		end else if (cy_q < exit_pos.y && cur.untried[DIR_DOWN]) begin
			dec_dir = DIR_DOWN;
		end else if (n_open >= 3'd2) begin
			dec_dir = cur.untried[cur.come] ? cur.come : fallback;
		end else if (n_open == 3'd1) begin
			dec_dir = fallback;
		end else begin
			dec_dir = reverse_dir(cur.come);
			dec_ret = 1'b1;
		end
	end

	assign load = (state_q == ST_DEC) && (!out_valid_q || result.ready);

	always_ff @(posedge clk) begin
		if (take) begin
			cx_q <= q_in.item.cell_x;
			cy_q <= q_in.item.cell_y;
		end
		if (take && !adv_e) begin
			pop_dir_q <= top_q.come;
		end
		if (load) begin
			out_dir_q   <= dec_dir;
			out_ret_q   <= dec_ret;
			out_fault_q <= fault_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			adv_q       <= 1'b1;
			last_q      <= DIR_LEFT;
			top_q       <= '0;
			fault_q     <= FAULT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						adv_q   <= adv_e;
						last_q  <= last_e;
						if (adv_e) begin
							state_q <= ST_DEC;
							if (cnt_e == CNT_W'(STACK_DEPTH)) begin
								fault_q <= FAULT_PUSH;
								count_q <= cnt_e;
							end else begin
								fault_q <= FAULT_NONE;
								top_q   <= new_frame;
								count_q <= cnt_e + 1'b1;
							end
						end else if (cnt_e == '0) begin
							state_q <= ST_DEC;
							fault_q <= FAULT_POP;
							count_q <= '0;
						end else begin
							fault_q <= FAULT_NONE;
							count_q <= cnt_e - 1'b1;
							state_q <= (cnt_e != CNT_W'(1)) ? ST_FIX : ST_DEC;
						end
					end
				end
				ST_FIX: begin
					top_q   <= fixed;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (load) begin
						state_q     <= ST_IDLE;
						if (dec_ret) begin
							adv_q <= 1'b0;
						end else begin
							adv_q  <= 1'b1;
							last_q <= dec_dir;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.move_dir    = out_dir_q;
	assign result.is_retreat  = out_ret_q;
	assign result.stack_fault = out_fault_q;

	assign stat.load  = load;
	assign stat.fault = fault_q;
	assign stat.count = count_q;

endmodule
